FILE: sv/tun_pkg.sv
// Shared constants and types of the triangle unit normal block.
`default_nettype none

package tun_pkg;

    // Field widths of the interface.
    localparam int COORD_BITS       = 24;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_WIDTH     = NORMAL_FRAC_BITS + 2;

    // Internal widths, all derived from the two above.
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * EDGE_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;
    localparam int MAG_BITS   = PROD_BITS;
    localparam int HALF_BITS  = (MAG_BITS + 1) / 2;
    localparam int HIGH_BITS  = MAG_BITS - HALF_BITS;
    localparam int SQ_BITS    = 2 * MAG_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int ACC_BITS   = SUM_BITS + 2 * NORMAL_FRAC_BITS + 6;
    localparam int Q_BITS     = NORMAL_FRAC_BITS + 1;
    localparam int STEPS      = NORMAL_FRAC_BITS + 1;

    localparam int QUEUE_DEPTH = 2;

    // One word handed from the front end to the back end.
    typedef struct packed {
        logic [2:0]               neg;
        logic [2:0][SQ_BITS-1:0]  sq;
        logic [SUM_BITS-1:0]      sum;
        logic                     degen;
    } t_job;

endpackage

`default_nettype wire

FILE: sv/tun_front.sv
// Front end: edge vectors, cross product, squared lengths and degenerate check.
`default_nettype none

module tun_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tun_pkg::COORD_BITS-1:0] i_pt [3][3],
    input  wire logic                          i_full,
    output logic                               o_en,
    output logic                               o_push,
    output tun_pkg::t_job                      o_job
);

    localparam int CB  = tun_pkg::COORD_BITS;
    localparam int EB  = tun_pkg::EDGE_BITS;
    localparam int PB  = tun_pkg::PROD_BITS;
    localparam int XB  = tun_pkg::CROSS_BITS;
    localparam int MB  = tun_pkg::MAG_BITS;
    localparam int LB  = tun_pkg::HALF_BITS;
    localparam int HB  = tun_pkg::HIGH_BITS;
    localparam int SQB = tun_pkg::SQ_BITS;
    localparam int SW  = tun_pkg::SUM_BITS;

    logic [5:0]              r_v;
    logic signed [CB-1:0]    r_pt [3][3];
    logic signed [EB-1:0]    r_e1 [3];
    logic signed [EB-1:0]    r_e2 [3];
    logic signed [PB-1:0]    r_pa [3];
    logic signed [PB-1:0]    r_pb [3];
    logic [MB-1:0]           r_mag [3];
    logic [2:0]              r_neg4;
    logic [2*HB-1:0]         r_hh [3];
    logic [HB+LB-1:0]        r_hl [3];
    logic [2*LB-1:0]         r_ll [3];
    logic [2:0]              r_neg5;
    logic [SQB-1:0]          r_sq [3];
    logic [2:0]              r_neg6;

    logic signed [EB-1:0]    n_e1 [3];
    logic signed [EB-1:0]    n_e2 [3];
    logic signed [PB-1:0]    n_pa [3];
    logic signed [PB-1:0]    n_pb [3];
    logic signed [XB-1:0]    w_diff [3];
    logic [MB-1:0]           n_mag [3];
    logic [2:0]              n_neg4;
    logic [SQB-1:0]          n_sq [3];
    logic [SW-1:0]           w_sum;

    // The whole front end moves together; it holds only when the queue is full.
    assign o_en   = !(r_v[5] && i_full);
    assign o_push = r_v[5] && !i_full;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e1[i] = EB'(r_pt[0][i]) - EB'(r_pt[1][i]);
            n_e2[i] = EB'(r_pt[1][i]) - EB'(r_pt[2][i]);
        end
        n_pa[0] = r_e1[1] * r_e2[2];
        n_pb[0] = r_e1[2] * r_e2[1];
        n_pa[1] = r_e1[2] * r_e2[0];
        n_pb[1] = r_e1[0] * r_e2[2];
        n_pa[2] = r_e1[0] * r_e2[1];
        n_pb[2] = r_e1[1] * r_e2[0];
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = XB'(r_pa[i]) - XB'(r_pb[i]);
            n_neg4[i] = w_diff[i][XB-1];
            n_mag[i]  = w_diff[i][XB-1] ? MB'(-w_diff[i]) : MB'(w_diff[i]);
            n_sq[i]   = (SQB'(r_hh[i]) << (2 * LB)) + (SQB'(r_hl[i]) << (LB + 1))
                      + SQB'(r_ll[i]);
        end
        w_sum = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    end

    always_comb begin
        o_job.neg   = r_neg6;
        o_job.sq[0] = r_sq[0];
        o_job.sq[1] = r_sq[1];
        o_job.sq[2] = r_sq[2];
        o_job.sum   = w_sum;
        o_job.degen = (w_sum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (o_en) begin
            r_v <= {r_v[4:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pt[i][j] <= $signed(i_pt[i][j]);
                end
                r_e1[i] <= n_e1[i];
                r_e2[i] <= n_e2[i];
                r_pa[i] <= n_pa[i];
                r_pb[i] <= n_pb[i];
                r_mag[i] <= n_mag[i];
                r_hh[i] <= r_mag[i][MB-1:LB] * r_mag[i][MB-1:LB];
                r_hl[i] <= r_mag[i][MB-1:LB] * r_mag[i][LB-1:0];
                r_ll[i] <= r_mag[i][LB-1:0] * r_mag[i][LB-1:0];
                r_sq[i] <= n_sq[i];
            end
            r_neg4 <= n_neg4;
            r_neg5 <= r_neg4;
            r_neg6 <= r_neg5;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tun_queue.sv
// Short queue of words between the front end and the back end.
`default_nettype none

module tun_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tun_pkg::t_job i_job,
    output logic               o_full,
    output logic               o_valid,
    output tun_pkg::t_job      o_job
);

    localparam int DEPTH = tun_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    tun_pkg::t_job  r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [PW:0]    r_cnt;
    logic           w_pop;

    // The back end never stalls, so the head word leaves as soon as it is there.
    assign w_pop   = (r_cnt != '0);
    assign o_valid = w_pop;
    assign o_job   = r_mem[r_rd];
    assign o_full  = (r_cnt == (PW + 1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW + 1)'(i_push) - (PW + 1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("word pushed into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW + 1)'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

FILE: sv/tun_back.sv
// Back end: pipelined rounded quotient by square-root recurrence, sign and output.
`default_nettype none

module tun_back (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    input  wire tun_pkg::t_job                         i_job,
    output logic                                       o_valid,
    output logic signed [tun_pkg::NORMAL_WIDTH-1:0]    o_nx,
    output logic signed [tun_pkg::NORMAL_WIDTH-1:0]    o_ny,
    output logic signed [tun_pkg::NORMAL_WIDTH-1:0]    o_nz,
    output logic                                       o_deg
);

    localparam int F   = tun_pkg::NORMAL_FRAC_BITS;
    localparam int NW  = tun_pkg::NORMAL_WIDTH;
    localparam int SW  = tun_pkg::SUM_BITS;
    localparam int AW  = tun_pkg::ACC_BITS;
    localparam int QB  = tun_pkg::Q_BITS;
    localparam int NS  = tun_pkg::STEPS;
    localparam int SQB = tun_pkg::SQ_BITS;

    // Stage k holds the state before bit F-k of the quotient is decided.
    // a = c^2 * 2^(2F+2) - w^2 * s and p = w * s, with w = 2q - 1.
    logic                  r_v   [NS+1];
    logic signed [AW-1:0]  r_a   [NS+1][3];
    logic signed [AW-1:0]  r_p   [NS+1][3];
    logic [QB-1:0]         r_q   [NS+1][3];
    logic [SW-1:0]         r_s   [NS+1];
    logic [2:0]            r_neg [NS+1];
    logic                  r_dg  [NS+1];

    logic signed [AW-1:0]  w_s0;
    logic [NW-1:0]         n_out [3];

    assign w_s0 = $signed({{(AW - SW){1'b0}}, i_job.sum});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a[0][i] <= ($signed({{(AW - SQB){1'b0}}, i_job.sq[i]}) <<< (2 * F + 2)) - w_s0;
            r_p[0][i] <= -w_s0;
            r_q[0][i] <= '0;
        end
        r_s[0]   <= i_job.sum;
        r_neg[0] <= i_job.neg;
        r_dg[0]  <= i_job.degen;
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        localparam int B = F - k;

        logic signed [AW-1:0] w_s;
        logic signed [AW-1:0] w_try [3];

        assign w_s = $signed({{(AW - SW){1'b0}}, r_s[k]});

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_try[i] = r_a[k][i] - (r_p[k][i] <<< (B + 2)) - (w_s <<< (2 * B + 2));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                if (!w_try[i][AW-1]) begin
                    r_a[k+1][i] <= w_try[i];
                    r_p[k+1][i] <= r_p[k][i] + (w_s <<< (B + 1));
                    r_q[k+1][i] <= r_q[k][i] | (QB'(1) << B);
                end else begin
                    r_a[k+1][i] <= r_a[k][i];
                    r_p[k+1][i] <= r_p[k][i];
                    r_q[k+1][i] <= r_q[k][i];
                end
            end
            r_s[k+1]   <= r_s[k];
            r_neg[k+1] <= r_neg[k];
            r_dg[k+1]  <= r_dg[k];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dg[NS]) begin
                n_out[i] = '0;
            end else if (r_neg[NS][i]) begin
                n_out[i] = -NW'(r_q[NS][i]);
            end else begin
                n_out[i] = NW'(r_q[NS][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        o_nx  <= $signed(n_out[0]);
        o_ny  <= $signed(n_out[1]);
        o_nz  <= $signed(n_out[2]);
        o_deg <= r_dg[NS];
    end

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_deg) |-> (o_nx == '0 && o_ny == '0 && o_nz == '0))
        else $error("degenerate result with a nonzero normal");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_nx <= $signed(NW'(1 << F)) && o_nx >= -$signed(NW'(1 << F))
                  && o_ny <= $signed(NW'(1 << F)) && o_ny >= -$signed(NW'(1 << F))
                  && o_nz <= $signed(NW'(1 << F)) && o_nz >= -$signed(NW'(1 << F))))
        else $error("normal component beyond unit magnitude");

endmodule

`default_nettype wire

FILE: sv/triangle_unit_normal.sv
// Top level of the triangle unit normal block.
// Path to the result strobe: the edge that accepts a word loads the first of six front stages,
// then come the hand-off queue, the input register and recurrence stages of the back end, and
// the output register. Throughput: one word per cycle while busy is low; every stage,
// including one quotient bit per stage of the square-root recurrence, is a fully pipelined
// step, and the back end drains one word a cycle.
// Reset is synchronous and active low; it clears only valid bits, queue pointers and count.
// The receiver cannot stall; busy rises only if the hand-off queue is full.
`default_nettype none

module triangle_unit_normal (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [tun_pkg::COORD_BITS-1:0]        i_first_x,
    input  wire logic [tun_pkg::COORD_BITS-1:0]        i_first_y,
    input  wire logic [tun_pkg::COORD_BITS-1:0]        i_first_z,
    input  wire logic [tun_pkg::COORD_BITS-1:0]        i_second_x,
    input  wire logic [tun_pkg::COORD_BITS-1:0]        i_second_y,
    input  wire logic [tun_pkg::COORD_BITS-1:0]        i_second_z,
    input  wire logic [tun_pkg::COORD_BITS-1:0]        i_third_x,
    input  wire logic [tun_pkg::COORD_BITS-1:0]        i_third_y,
    input  wire logic [tun_pkg::COORD_BITS-1:0]        i_third_z,
    output logic                                       o_strobe,
    output logic signed [tun_pkg::NORMAL_WIDTH-1:0]    o_normal_x,
    output logic signed [tun_pkg::NORMAL_WIDTH-1:0]    o_normal_y,
    output logic signed [tun_pkg::NORMAL_WIDTH-1:0]    o_normal_z,
    output logic                                       o_degenerate
);

    // Vertex coordinates gathered as [vertex][axis].
    logic [tun_pkg::COORD_BITS-1:0] w_pt [3][3];

    logic           w_en;
    logic           w_push;
    logic           w_full;
    logic           w_qvalid;
    tun_pkg::t_job  w_job_in;
    tun_pkg::t_job  w_job_out;

    assign w_pt[0][0] = i_first_x;
    assign w_pt[0][1] = i_first_y;
    assign w_pt[0][2] = i_first_z;
    assign w_pt[1][0] = i_second_x;
    assign w_pt[1][1] = i_second_y;
    assign w_pt[1][2] = i_second_z;
    assign w_pt[2][0] = i_third_x;
    assign w_pt[2][1] = i_third_y;
    assign w_pt[2][2] = i_third_z;

    // The front end holds a word only while the queue is full.
    assign busy = !w_en;

    // The front end forms the edges, the exact cross product, its squared
    // length and flags the zero-length case before handing the word on.
    tun_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_pt    (w_pt),
        .i_full  (w_full),
        .o_en    (w_en),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    tun_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_job   (w_job_out)
    );

    // The back end resolves each quotient bit by an exact comparison of
    // squares, which yields the length division rounded to nearest.
    tun_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_job   (w_job_out),
        .o_valid (o_strobe),
        .o_nx    (o_normal_x),
        .o_ny    (o_normal_y),
        .o_nz    (o_normal_z),
        .o_deg   (o_degenerate)
    );

endmodule

`default_nettype wire

FILE: tb/sv/triangle_unit_normal_tb.sv
// Self-checking testbench for the triangle unit normal block: directed table then random triangles.
`timescale 1ns / 100ps
`default_nettype none

module triangle_unit_normal_tb;

    localparam int  COORD_BITS       = tun_pkg::COORD_BITS;
    localparam int  NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS;
    localparam int  NORMAL_WIDTH     = tun_pkg::NORMAL_WIDTH;
    localparam int  Q_BITS           = tun_pkg::Q_BITS;

    localparam int  HALF_PERIOD  = 5;
    localparam int  RESET_CYCLES = 8;
    localparam int  RANDOM_WORDS = 1050;
    localparam int  MAX_GAP      = 8;
    // Extra wait at the end, with a margin beyond the delay from acceptance to the strobe.
    localparam int  DRAIN_CYCLES = 40;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam logic signed [COORD_BITS-1:0] ONE_Q12 = 24'sd4096;
    localparam logic signed [NORMAL_WIDTH-1:0] UNIT_Q14 = 16'sd16384;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [255:0]                 t_big;

    // One triangle: vertex fields in port order.
    typedef struct {
        t_coord v [9];
    } t_tri;

    // One unit normal as it appears on the result ports.
    typedef struct {
        logic signed [NORMAL_WIDTH-1:0] nx;
        logic signed [NORMAL_WIDTH-1:0] ny;
        logic signed [NORMAL_WIDTH-1:0] nz;
        logic                           degen;
    } t_normal;

    // A directed row: the triangle and, where it is obvious, the normal it must give.
    typedef struct {
        t_tri    tri_in;
        bit      known;
        t_normal want;
    } t_row;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_coord coord [9];
    logic   o_strobe;
    logic signed [NORMAL_WIDTH-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic   o_degenerate;

    t_normal pending_normals [$];
    t_row    directed [$];
    int      fail_count = 0;
    int      cycle_count = 0;

    initial begin
        for (int k = 0; k < 9; k++) coord[k] = '0;
    end

    always #HALF_PERIOD i_clk = ~i_clk;

    triangle_unit_normal uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_first_x    (coord[0]),
        .i_first_y    (coord[1]),
        .i_first_z    (coord[2]),
        .i_second_x   (coord[3]),
        .i_second_y   (coord[4]),
        .i_second_z   (coord[5]),
        .i_third_x    (coord[6]),
        .i_third_y    (coord[7]),
        .i_third_z    (coord[8]),
        .o_strobe     (o_strobe),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z),
        .o_degenerate (o_degenerate)
    );

    // Rounded |c| * 2^F / |s|^(1/2), found bit by bit: a candidate q is kept when
    // (2q - 1)^2 * s <= c^2 * 2^(2F+2), which rounds to nearest with ties going up.
    function automatic logic [Q_BITS-1:0] rounded_ratio(input t_big cmag, input t_big sumsq);
        t_big rhs, odd, lhs;
        logic [Q_BITS-1:0] q, cand;
        rhs = (cmag * cmag) << (2 * NORMAL_FRAC_BITS + 2);
        q = '0;
        for (int b = NORMAL_FRAC_BITS; b >= 0; b--) begin
            cand = q | (Q_BITS'(1) << b);
            odd = 2 * t_big'(cand) - 1;
            lhs = odd * odd * sumsq;
            if (lhs <= rhs) q = cand;
        end
        return q;
    endfunction

    // Unit face normal of a triangle, computed exactly in wide integers.
    function automatic t_normal face_normal(input t_tri t);
        longint e1 [3], e2 [3], c [3];
        t_big mag [3], sumsq;
        logic [Q_BITS-1:0] q;
        logic signed [NORMAL_WIDTH-1:0] comp [3];
        t_normal r;
        for (int j = 0; j < 3; j++) begin
            e1[j] = longint'(t.v[j]) - longint'(t.v[3 + j]);
            e2[j] = longint'(t.v[3 + j]) - longint'(t.v[6 + j]);
        end
        // Edges are 25 bits, so every product and difference fits in 64 bits.
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        sumsq = '0;
        for (int j = 0; j < 3; j++) begin
            mag[j] = t_big'(c[j] < 0 ? -c[j] : c[j]);
            sumsq += mag[j] * mag[j];
        end
        if (sumsq == '0) begin
            r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
            return r;
        end
        for (int j = 0; j < 3; j++) begin
            q = rounded_ratio(mag[j], sumsq);
            comp[j] = c[j] < 0 ? -NORMAL_WIDTH'(q) : NORMAL_WIDTH'(q);
        end
        r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2]; r.degen = 1'b0;
        return r;
    endfunction

    function automatic t_tri make_tri(input t_coord a0, a1, a2, b0, b1, b2,
                                      input t_coord c0, c1, c2);
        t_tri t;
        t.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        return t;
    endfunction

    function automatic t_coord rand_coord(input int span);
        if (span >= COORD_BITS) return t_coord'($urandom);
        return t_coord'($signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1)));
    endfunction

    // Random triangle: mostly well spread with varied magnitudes, some degenerate.
    function automatic t_tri rand_tri();
        t_tri t;
        int kind, span;
        longint dx, dy, dz;
        kind = $urandom_range(0, 9);
        span = $urandom_range(0, 1) ? COORD_BITS : $urandom_range(2, COORD_BITS);
        for (int k = 0; k < 9; k++) t.v[k] = rand_coord(span);
        case (kind)
            0: begin
                // Repeated vertex: the cross product vanishes.
                for (int k = 0; k < 3; k++) t.v[6 + k] = t.v[3 + k];
            end
            1: begin
                // Collinear: third vertex continues the first edge once more.
                for (int k = 0; k < 3; k++) begin
                    t.v[k] = rand_coord(20);
                    t.v[3 + k] = rand_coord(20);
                    t.v[6 + k] = t_coord'(2 * longint'(t.v[3 + k]) - longint'(t.v[k]));
                end
            end
            2: begin
                // Thin triangle: nearly or exactly collinear, with a kink of zero or one in z.
                dx = longint'(rand_coord(10)); dy = longint'(rand_coord(10));
                dz = longint'(rand_coord(10));
                t.v[6] = t_coord'(longint'(t.v[3]) - dx);
                t.v[7] = t_coord'(longint'(t.v[4]) - dy);
                t.v[8] = t_coord'(longint'(t.v[5]) - dz + $urandom_range(0, 1));
                t.v[0] = t_coord'(longint'(t.v[3]) + dx);
                t.v[1] = t_coord'(longint'(t.v[4]) + dy);
                t.v[2] = t_coord'(longint'(t.v[5]) + dz);
            end
            default: ;
        endcase
        return t;
    endfunction

    // Present one triangle after a gap and hold it until the block takes it.
    task automatic send_triangle(input t_tri t, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        for (int k = 0; k < 9; k++) coord[k] <= t.v[k];
        do @(posedge i_clk); while (busy);
        pending_normals.push_back(face_normal(t));
    endtask

    task automatic check_field(input string label, input logic [NORMAL_WIDTH-1:0] want,
                               input logic [NORMAL_WIDTH-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label,
                     $signed(want), $signed(got));
            fail_count++;
        end
    endtask

    // Every strobed word is checked against the oldest outstanding normal.
    always @(posedge i_clk) begin
        t_normal want;
        if (i_rst_n && o_strobe) begin
            if (pending_normals.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %0d %0d %0d %0b", $time,
                         o_normal_x, o_normal_y, o_normal_z, o_degenerate);
                fail_count++;
            end else begin
                want = pending_normals.pop_front();
                check_field("normal_x", want.nx, o_normal_x);
                check_field("normal_y", want.ny, o_normal_y);
                check_field("normal_z", want.nz, o_normal_z);
                check_field("degenerate", NORMAL_WIDTH'(want.degen), NORMAL_WIDTH'(o_degenerate));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_row(input t_tri t, input bit known, input t_normal want);
        t_row r;
        r.tri_in = t; r.known = known; r.want = want;
        directed.push_back(r);
    endtask

    initial begin
        t_normal zero_normal, plus_z, minus_z, none;
        t_coord hi, lo;
        hi = {1'b0, {(COORD_BITS-1){1'b1}}};
        lo = {1'b1, {(COORD_BITS-1){1'b0}}};
        zero_normal = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
        plus_z  = '{nx: '0, ny: '0, nz: UNIT_Q14, degen: 1'b0};
        minus_z = '{nx: '0, ny: '0, nz: -UNIT_Q14, degen: 1'b0};
        none    = zero_normal;

        // Directed table. Rows with a typed-in normal are the degenerate cases and the
        // axis-aligned unit triangles in the xy plane; the rest are left to the predictor.
        add_row(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_normal);
        add_row(make_tri(hi, hi, hi, hi, hi, hi, hi, hi, hi), 1, zero_normal);
        add_row(make_tri(lo, lo, lo, lo, lo, lo, lo, lo, lo), 1, zero_normal);
        add_row(make_tri(lo, 0, hi, 0, 0, 0, hi, 0, lo), 0, none);
        add_row(make_tri(ONE_Q12, 0, 0, 0, 0, 0, 0, -ONE_Q12, 0), 1, plus_z);
        add_row(make_tri(ONE_Q12, 0, 0, 0, 0, 0, 0, ONE_Q12, 0), 1, minus_z);
        add_row(make_tri(0, ONE_Q12, 0, 0, 0, 0, 0, 0, -ONE_Q12), 0, none);
        add_row(make_tri(0, 0, ONE_Q12, 0, 0, 0, -ONE_Q12, 0, 0), 0, none);
        add_row(make_tri(hi, 0, 0, lo, 0, 0, lo, hi, 0), 0, none);
        add_row(make_tri(lo, lo, lo, hi, hi, lo, hi, lo, hi), 0, none);
        add_row(make_tri(hi, lo, hi, lo, hi, lo, hi, hi, lo), 0, none);
        add_row(make_tri(hi, hi, lo, lo, lo, hi, hi, lo, lo), 0, none);
        add_row(make_tri(1, 0, 0, 0, 0, 0, 0, 1, 0), 0, none);
        add_row(make_tri(1, 1, 1, 0, 0, 0, 1, 2, 3), 0, none);
        add_row(make_tri(-1, -1, -1, 0, 0, 0, 1, 1, 1), 1, zero_normal);
        add_row(make_tri(hi, hi, hi, 0, 0, 0, lo + 1, lo + 1, lo + 1), 1, zero_normal);
        add_row(make_tri(3, 0, 0, 0, 0, 0, 0, 4, 0), 0, none);
        add_row(make_tri(hi, 0, 0, 0, 0, 0, 0, 1, 0), 0, none);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send_triangle(directed[i].tri_in, i % 3);
            if (directed[i].known) begin
                // The typed-in value replaces the prediction for this row.
                pending_normals[pending_normals.size() - 1] = directed[i].want;
            end
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) begin
                // Let the pipeline run dry once before carrying on.
                start <= 1'b0;
                while (pending_normals.size() != 0) @(posedge i_clk);
            end
            // Long runs without gaps alternate with runs of random gaps.
            send_triangle(rand_tri(), ((n / 64) % 2) ? 0 : $urandom_range(0, MAX_GAP));
        end
        start <= 1'b0;

        while (pending_normals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
